// ----- sv/periodic_task_timer_table_core_defines.svh -----
// Assertion macros shared by the checker of the periodic timer table core.
// Needs a clock named clk and an active-low reset named rst_n in the using scope.
`ifndef PERIODIC_TASK_TIMER_TABLE_CORE_DEFINES_SVH
`define PERIODIC_TASK_TIMER_TABLE_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PTT_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PTT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/ptt_pkg.sv -----
// Package of the periodic timer table core: field widths, request and result codes,
// and the command and status structs between controller and datapath. No dependencies.
`timescale 1ns / 1ps

package ptt_pkg;

    localparam int REQ_W  = 2;
    localparam int NOW_W  = 32;
    localparam int IVL_W  = 31;
    localparam int SLOT_W = 4;
    localparam int KIND_W = 2;

    localparam logic [REQ_W-1:0] REQ_ADD    = 2'd0;
    localparam logic [REQ_W-1:0] REQ_PAUSE  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_RESUME = 2'd2;
    localparam logic [REQ_W-1:0] REQ_TICK   = 2'd3;

    localparam logic [KIND_W-1:0] KIND_FIRED = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ACK   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DONE  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_ERROR = 2'd3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;    // latch the incoming request
        logic cur_clear;  // restart the slot cursor
        logic op_commit;  // apply add, pause or resume and load its result
        logic tick_step;  // finish the current slot of a tick
        logic done_emit;  // load the tick done result
    } ptt_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;   // output register can take a result this cycle
        logic tick_empty; // no used slots
        logic cur_last;   // cursor sits on the last used slot
        logic need_out;   // current slot is due and active
    } ptt_sts_t;

endpackage

// ----- sv/ptt_if.sv -----
// Request and result channel interfaces of the periodic timer table core.
// Depends on ptt_pkg for the field widths.
`timescale 1ns / 1ps

interface ptt_req_if;
    logic                          valid;
    logic                          ready;
    logic [ptt_pkg::REQ_W-1:0]     req_type;
    logic [ptt_pkg::NOW_W-1:0]     now_ms;
    logic [ptt_pkg::IVL_W-1:0]     interval_ms;
    logic [ptt_pkg::SLOT_W-1:0]    slot;

    modport source (output valid, output req_type, output now_ms, output interval_ms,
                    output slot, input ready);
    modport sink   (input valid, input req_type, input now_ms, input interval_ms,
                    input slot, output ready);
endinterface

interface ptt_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [ptt_pkg::KIND_W-1:0]    kind;
    logic [ptt_pkg::SLOT_W-1:0]    slot_out;
    logic                          last;

    modport source (output valid, output kind, output slot_out, output last, input ready);
    modport sink   (input valid, input kind, input slot_out, input last, output ready);
endinterface

// ----- sv/ptt_ctrl.sv -----
// Controller state machine of the periodic timer table core.
// Depends on ptt_pkg for the request codes and the command and status structs.
`timescale 1ns / 1ps

module ptt_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        req_valid,
    input  logic [ptt_pkg::REQ_W-1:0]   req_type,
    output logic                        req_ready,
    input  ptt_pkg::ptt_sts_t           sts,
    output ptt_pkg::ptt_cmd_t           cmd
);
    import ptt_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_OP    = 3'd1;
    localparam logic [2:0] S_TREAD = 3'd2;
    localparam logic [2:0] S_TEVAL = 3'd3;
    localparam logic [2:0] S_TDONE = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign req_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.capture = 1'b1;
                    if (req_type == REQ_TICK)
                    begin
                        cmd.cur_clear = 1'b1;
                        state_next    = sts.tick_empty ? S_TDONE : S_TREAD;
                    end
                    else
                    begin
                        state_next = S_OP;
                    end
                end
            end
            S_OP:
            begin
                if (sts.out_free)
                begin
                    cmd.op_commit = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_TREAD:
            begin
                state_next = S_TEVAL;
            end
            S_TEVAL:
            begin
                // A slot that emits nothing never waits on the output.
                if (!sts.need_out || sts.out_free)
                begin
                    cmd.tick_step = 1'b1;
                    state_next    = sts.cur_last ? S_TDONE : S_TREAD;
                end
            end
            S_TDONE:
            begin
                if (sts.out_free)
                begin
                    cmd.done_emit = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- sv/ptt_dpath.sv -----
// Datapath of the periodic timer table core: slot stores, active marks, slot count,
// tick cursor, due compare and the result register. Depends on ptt_pkg and ptt_if.
`timescale 1ns / 1ps

module ptt_dpath #(
    parameter int SLOTS = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [ptt_pkg::REQ_W-1:0]   req_type,
    input  logic [ptt_pkg::NOW_W-1:0]   now_ms,
    input  logic [ptt_pkg::IVL_W-1:0]   interval_ms,
    input  logic [ptt_pkg::SLOT_W-1:0]  slot,
    input  ptt_pkg::ptt_cmd_t           cmd,
    output ptt_pkg::ptt_sts_t           sts,
    ptt_rsp_if.source                   rsp
);
    import ptt_pkg::*;

    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int SEL_W = (CNT_W > SLOT_W) ? CNT_W : SLOT_W;

    // Latched request.
    logic [REQ_W-1:0]  rq_type_reg;
    logic [NOW_W-1:0]  now_reg;
    logic [IVL_W-1:0]  ivl_reg;
    logic [SLOT_W-1:0] sel_reg;

    // Table state.
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [SLOTS-1:0]  active_reg;
    logic [SLOTS-1:0]  active_next;
    logic [IDX_W-1:0]  cursor_reg;
    logic [IDX_W-1:0]  cursor_next;

    logic [IVL_W-1:0]  ivl_mem [SLOTS];
    logic [NOW_W-1:0]  lt_mem  [SLOTS];
    logic [IVL_W-1:0]  ivl_rd_reg;
    logic [NOW_W-1:0]  lt_rd_reg;

    // Result register.
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [KIND_W-1:0] out_kind_reg;
    logic [KIND_W-1:0] out_kind_next;
    logic [SLOT_W-1:0] out_slot_reg;
    logic [SLOT_W-1:0] out_slot_next;
    logic              out_last_reg;
    logic              out_last_next;

    logic              table_full;
    logic [SEL_W-1:0]  sel_ext;
    logic              sel_ok;
    logic [IDX_W-1:0]  sel_idx;
    logic [IDX_W-1:0]  add_idx;
    logic [NOW_W-1:0]  due_time;
    logic              due;
    logic              ivl_we;
    logic              lt_we;
    logic [IDX_W-1:0]  wr_addr;
    logic [NOW_W-1:0]  lt_wdata;

    assign table_full = (count_reg == CNT_W'(SLOTS));
    assign sel_ext    = SEL_W'(sel_reg);
    assign sel_ok     = (sel_ext < SEL_W'(count_reg));
    assign sel_idx    = sel_ext[IDX_W-1:0];
    assign add_idx    = count_reg[IDX_W-1:0];

    // Wrapping 32-bit sum, unsigned compare.
    assign due_time = lt_rd_reg + NOW_W'(ivl_rd_reg);
    assign due      = (now_reg >= due_time);

    assign sts.out_free   = !out_valid_reg || rsp.ready;
    assign sts.tick_empty = (count_reg == '0);
    assign sts.cur_last   = ((CNT_W'(cursor_reg) + CNT_W'(1)) == count_reg);
    assign sts.need_out   = due && active_reg[cursor_reg];

    assign rsp.valid    = out_valid_reg;
    assign rsp.kind     = out_kind_reg;
    assign rsp.slot_out = out_slot_reg;
    assign rsp.last     = out_last_reg;

    always_comb
    begin
        count_next     = count_reg;
        active_next    = active_reg;
        cursor_next    = cursor_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_kind_next  = out_kind_reg;
        out_slot_next  = out_slot_reg;
        out_last_next  = out_last_reg;
        ivl_we         = 1'b0;
        lt_we          = 1'b0;
        wr_addr        = cursor_reg;
        lt_wdata       = now_reg;

        if (cmd.cur_clear)
        begin
            cursor_next = '0;
        end

        if (cmd.op_commit)
        begin
            out_valid_next = 1'b1;
            out_last_next  = 1'b1;
            case (rq_type_reg)
                REQ_ADD:
                begin
                    if (table_full)
                    begin
                        out_kind_next = KIND_ERROR;
                        out_slot_next = '0;
                    end
                    else
                    begin
                        ivl_we               = 1'b1;
                        lt_we                = 1'b1;
                        wr_addr              = add_idx;
                        active_next[add_idx] = 1'b1;
                        count_next           = count_reg + CNT_W'(1);
                        out_kind_next        = KIND_ACK;
                        out_slot_next        = SLOT_W'(count_reg);
                    end
                end
                REQ_PAUSE, REQ_RESUME:
                begin
                    out_slot_next = sel_reg;
                    if (sel_ok)
                    begin
                        active_next[sel_idx] = (rq_type_reg == REQ_RESUME);
                        out_kind_next        = KIND_ACK;
                    end
                    else
                    begin
                        out_kind_next = KIND_ERROR;
                    end
                end
                default:
                begin
                    out_kind_next = KIND_ERROR;
                    out_slot_next = '0;
                end
            endcase
        end

        if (cmd.tick_step)
        begin
            lt_we       = due;
            cursor_next = cursor_reg + IDX_W'(1);
            if (due && active_reg[cursor_reg])
            begin
                out_valid_next = 1'b1;
                out_kind_next  = KIND_FIRED;
                out_slot_next  = SLOT_W'(cursor_reg);
                out_last_next  = 1'b0;
            end
        end

        if (cmd.done_emit)
        begin
            out_valid_next = 1'b1;
            out_kind_next  = KIND_DONE;
            out_slot_next  = '0;
            out_last_next  = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            rq_type_reg <= req_type;
            now_reg     <= now_ms;
            ivl_reg     <= interval_ms;
            sel_reg     <= slot;
        end
        out_kind_reg <= out_kind_next;
        out_slot_reg <= out_slot_next;
        out_last_reg <= out_last_next;
    end

    // Slot stores: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (ivl_we)
        begin
            ivl_mem[wr_addr] <= ivl_reg;
        end
        if (lt_we)
        begin
            lt_mem[wr_addr] <= lt_wdata;
        end
        ivl_rd_reg <= ivl_mem[cursor_reg];
        lt_rd_reg  <= lt_mem[cursor_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            active_reg    <= '0;
            cursor_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            active_reg    <= active_next;
            cursor_reg    <= cursor_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ----- sv/periodic_task_timer_table_core.sv -----
// Top level of the periodic timer table core: controller plus datapath.
// Depends on ptt_pkg, ptt_if, ptt_ctrl and ptt_dpath.
//
//   Channel  Direction  Payload                                  Handshake
//   req      in         req_type, now_ms, interval_ms, slot      valid / ready
//   rsp      out        kind, slot_out, last                     valid / ready
//
// Add, pause and resume go through the accepting state and a commit state; a tick with
// N used slots goes through the accepting cycle, a store read and a compare per slot, and
// the done result. Reset clears the state machine, slot count, cursor, active marks and
// result valid; the slot stores are not cleared, as only used slots are read.
// A result that waits on rsp.ready holds the walk; a new request is taken while the last
// result of the previous one still waits.
`timescale 1ns / 1ps

module periodic_task_timer_table_core #(
    parameter int SLOTS = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    ptt_req_if.sink    req,
    ptt_rsp_if.source  rsp
);
    import ptt_pkg::*;

    // Command and status between the state machine and the datapath.
    ptt_cmd_t cmd;
    ptt_sts_t sts;
    logic     ctrl_ready;

    // The request channel is ready only while the controller is idle; the
    // request fields are latched by the datapath on the accepting edge.
    assign req.ready = ctrl_ready;

    ptt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_type  (req.req_type),
        .req_ready (ctrl_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // The datapath owns the slot stores, the marks, the count, the cursor of a
    // tick walk and the result register that drives the rsp channel.
    ptt_dpath #(
        .SLOTS (SLOTS)
    ) u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_type    (req.req_type),
        .now_ms      (req.now_ms),
        .interval_ms (req.interval_ms),
        .slot        (req.slot),
        .cmd         (cmd),
        .sts         (sts),
        .rsp         (rsp)
    );

endmodule

// ----- sv/ptt_chk.sv -----
// Port-level checker of the periodic timer table core, bound to the top level.
// Depends on ptt_pkg and the assertion macros of the core's defines header.
`timescale 1ns / 1ps
`include "periodic_task_timer_table_core_defines.svh"

module ptt_chk (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        req_valid,
    input  logic                        req_ready,
    input  logic                        rsp_valid,
    input  logic                        rsp_ready,
    input  logic [ptt_pkg::KIND_W-1:0]  rsp_kind,
    input  logic [ptt_pkg::SLOT_W-1:0]  rsp_slot_out,
    input  logic                        rsp_last
);
    import ptt_pkg::*;

    // A stalled result keeps its valid and its payload.
    `PTT_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_kind) && $stable(rsp_slot_out) && $stable(rsp_last), "stalled result changed")

    // Only fired results are not final.
    `PTT_ASSERT_SAME(a_last_kind, rsp_valid, rsp_last == (rsp_kind != KIND_FIRED), "last flag does not match kind")

    // A tick done result always carries slot zero.
    `PTT_ASSERT_SAME(a_done_slot, rsp_valid && (rsp_kind == KIND_DONE), rsp_slot_out == '0, "done result with nonzero slot")

    // One request at a time: ready drops after every accepted request.
    `PTT_ASSERT_NEXT(a_one_req, req_valid && req_ready, !req_ready, "ready held after a request")

endmodule

bind periodic_task_timer_table_core ptt_chk u_ptt_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_valid    (req.valid),
    .req_ready    (req.ready),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .rsp_kind     (rsp.kind),
    .rsp_slot_out (rsp.slot_out),
    .rsp_last     (rsp.last)
);

// ----- bench/ptt_timer_checker.sv -----
// Checker for the periodic timer table core: watches both channels, keeps its own copy
// of the timer table, predicts every result and compares field by field.
// Depends on ptt_pkg and the ptt_req_if / ptt_rsp_if interfaces.
`timescale 1ns / 1ps

module ptt_timer_checker #(
    parameter int SLOTS = 16
) (
    input  logic clk,
    input  logic rst_n,
    ptt_req_if   req,
    ptt_rsp_if   rsp,
    output int   fail_count,
    output int   outstanding,
    output int   result_count,
    output int   fired_count
);
    import ptt_pkg::*;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [SLOT_W-1:0] slot_out;
        logic              last;
    } timer_result_t;

    // Shadow copy of the timer table.
    logic [IVL_W-1:0] period_mem [SLOTS];
    logic [NOW_W-1:0] stamp_mem  [SLOTS];
    logic             armed      [SLOTS];
    int               used_slots;

    timer_result_t    awaited_results [$];
    int               mismatches;
    int               seen;
    int               fired;

    function automatic void check_field(input string name, input logic [3:0] want,
                                        input logic [3:0] got);
        if (want !== got)
        begin
            mismatches++;
            $display("%0t: result %0d field %s expected %0d, got %0d",
                     $time, seen, name, want, got);
        end
    endfunction

    // Applies one request to the shadow table and queues the results it causes.
    task automatic apply_timer_request(input logic [REQ_W-1:0]  op,
                                       input logic [NOW_W-1:0]  now,
                                       input logic [IVL_W-1:0]  period,
                                       input logic [SLOT_W-1:0] sel);
        logic [NOW_W-1:0] due;
        case (op)
            REQ_ADD:
            begin
                if (used_slots >= SLOTS)
                begin
                    awaited_results.push_back(timer_result_t'{KIND_ERROR, SLOT_W'(0), 1'b1});
                end
                else
                begin
                    period_mem[used_slots] = period;
                    stamp_mem[used_slots]  = now;
                    armed[used_slots]      = 1'b1;
                    awaited_results.push_back(
                        timer_result_t'{KIND_ACK, SLOT_W'(used_slots), 1'b1});
                    used_slots++;
                end
            end
            REQ_PAUSE, REQ_RESUME:
            begin
                if (int'(sel) < used_slots)
                begin
                    armed[sel] = (op == REQ_RESUME);
                    awaited_results.push_back(timer_result_t'{KIND_ACK, sel, 1'b1});
                end
                else
                begin
                    awaited_results.push_back(timer_result_t'{KIND_ERROR, sel, 1'b1});
                end
            end
            REQ_TICK:
            begin
                for (int i = 0; i < used_slots; i++)
                begin
                    // Wrapping 32-bit sum, unsigned compare.
                    due = stamp_mem[i] + NOW_W'(period_mem[i]);
                    if (now >= due)
                    begin
                        stamp_mem[i] = now;
                        if (armed[i])
                        begin
                            awaited_results.push_back(
                                timer_result_t'{KIND_FIRED, SLOT_W'(i), 1'b0});
                        end
                    end
                end
                awaited_results.push_back(timer_result_t'{KIND_DONE, SLOT_W'(0), 1'b1});
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        timer_result_t want;
        if (!rst_n)
        begin
            awaited_results.delete();
            used_slots = 0;
            for (int i = 0; i < SLOTS; i++)
            begin
                armed[i] = 1'b0;
            end
            mismatches = 0;
            seen       = 0;
            fired      = 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (rsp.kind == KIND_FIRED)
                begin
                    fired++;
                end
                if (awaited_results.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: result %0d expected none, got kind %0d slot %0d last %0d",
                             $time, seen, rsp.kind, rsp.slot_out, rsp.last);
                end
                else
                begin
                    want = awaited_results.pop_front();
                    check_field("kind", 4'(want.kind), 4'(rsp.kind));
                    check_field("slot_out", want.slot_out, rsp.slot_out);
                    check_field("last", 4'(want.last), 4'(rsp.last));
                end
                seen++;
            end
            if (req.valid && req.ready)
            begin
                apply_timer_request(req.req_type, req.now_ms, req.interval_ms, req.slot);
            end
        end
        fail_count   <= mismatches;
        outstanding  <= awaited_results.size();
        result_count <= seen;
        fired_count  <= fired;
    end

endmodule

// ----- bench/tb_periodic_task_timer_table_core.sv -----
// Top of the periodic timer table testbench: clock, reset, request stimulus and result
// back-pressure, plus the final verdict. Depends on ptt_pkg, ptt_if, the core and
// ptt_timer_checker, which does all prediction and comparison.
`timescale 1ns / 1ps

module tb_periodic_task_timer_table_core;
    import ptt_pkg::*;

    localparam int SLOTS        = 16;
    localparam int TOTAL_REQS   = 480;
    // The one long stretch in which the result side refuses everything.
    localparam int LONG_HOLD    = 90;
    // Outlasts a full tick over every slot, so this covers any late extra result.
    localparam int DRAIN_CYCLES = 2 * SLOTS + 8;
    // Cycles without any accepted request or result before the run is declared hung.
    localparam int STALL_LIMIT  = 4000;

    logic clk;
    logic rst_n;

    ptt_req_if req();
    ptt_rsp_if rsp();

    int fail_count;
    int outstanding;
    int result_count;
    int fired_count;
    int sent_reqs;

    // Set for the last part of the run: neither side inserts idle cycles any more.
    bit calm;
    // Raised once by the stimulus; the result side answers it with the long hold.
    bit long_hold_pending;

    // Running time base for well-formed tick sequences.
    logic [NOW_W-1:0] clock_ms;

    periodic_task_timer_table_core #(
        .SLOTS (SLOTS)
    ) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    ptt_timer_checker #(
        .SLOTS (SLOTS)
    ) u_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .req          (req),
        .rsp          (rsp),
        .fail_count   (fail_count),
        .outstanding  (outstanding),
        .result_count (result_count),
        .fired_count  (fired_count)
    );

    // 10 ns clock, first rising edge at 5 ns.
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Reset is asserted from time zero and released at a clock edge.
    initial
    begin
        rst_n <= 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Offers one request and returns at the edge where it is accepted. Valid stays high
    // on return, so a following request goes out back to back without a dip.
    task automatic push_request(input logic [REQ_W-1:0]  op,
                                input logic [NOW_W-1:0]  now,
                                input logic [IVL_W-1:0]  period,
                                input logic [SLOT_W-1:0] sel);
        req.valid       <= 1'b1;
        req.req_type    <= op;
        req.now_ms      <= now;
        req.interval_ms <= period;
        req.slot        <= sel;
        @(posedge clk);
        while (req.ready !== 1'b1)
        begin
            @(posedge clk);
        end
        sent_reqs++;
    endtask

    // A tick carries junk in the fields it does not use, so those bits toggle too.
    task automatic send_tick(input logic [NOW_W-1:0] now);
        push_request(REQ_TICK, now, IVL_W'($urandom), SLOT_W'($urandom));
    endtask

    // Drops valid for a random burst; the payload is scrambled meanwhile
    // to show that the block ignores it while valid is low.
    task automatic idle_gap();
        req.valid       <= 1'b0;
        req.req_type    <= REQ_W'($urandom);
        req.now_ms      <= $urandom;
        req.interval_ms <= IVL_W'($urandom);
        req.slot        <= SLOT_W'($urandom);
        repeat ($urandom_range(1, 6)) @(posedge clk);
    endtask

    // Request side.
    initial
    begin : stimulus
        int pick;
        int hold_at;
        bit hold_armed;

        req.valid       <= 1'b0;
        req.req_type    <= REQ_TICK;
        req.now_ms      <= '0;
        req.interval_ms <= '0;
        req.slot        <= '0;
        calm              = 1'b0;
        long_hold_pending = 1'b0;
        hold_armed        = 1'b0;
        sent_reqs         = 0;

        wait (rst_n === 1'b1);
        @(posedge clk);

        // Directed opening. An empty table answers a tick with the done result alone,
        // and pause or resume of a slot that was never added is an error.
        send_tick(32'd0);
        push_request(REQ_PAUSE, $urandom, IVL_W'($urandom), 4'd0);
        push_request(REQ_RESUME, $urandom, IVL_W'($urandom), 4'd15);

        // Slot 0 has a zero interval and is due on every tick from time zero. Slot 1 has
        // the largest interval at the largest time, so its due time wraps past zero.
        push_request(REQ_ADD, 32'd0, 31'd0, SLOT_W'($urandom));
        push_request(REQ_ADD, 32'hFFFF_FFFF, 31'h7FFF_FFFF, SLOT_W'($urandom));
        push_request(REQ_ADD, 32'd100, 31'd50, SLOT_W'($urandom));

        // A paused slot that comes due still takes the new trigger time but stays silent.
        push_request(REQ_PAUSE, $urandom, IVL_W'($urandom), 4'd2);
        send_tick(32'd200);
        push_request(REQ_RESUME, $urandom, IVL_W'($urandom), 4'd2);
        send_tick(32'd250);

        // The slot just past the used ones is still unused.
        push_request(REQ_PAUSE, $urandom, IVL_W'($urandom), 4'd3);

        // Fill the table with short periods so that ticks fire often later on.
        for (int k = 3; k < SLOTS; k++)
        begin
            push_request(REQ_ADD, NOW_W'(260 + 5 * k), IVL_W'($urandom_range(1, 60)),
                         SLOT_W'($urandom));
        end

        // A full table refuses the add. A tick at the top of the time range makes every
        // slot due and so gives the longest possible answer.
        push_request(REQ_ADD, $urandom, IVL_W'($urandom), SLOT_W'($urandom));
        send_tick(32'hFFFF_FFFF);

        // Random part. Most ticks follow a slowly advancing time base so slots come due
        // at their own pace. Now and then a tick carries a wild time, which is followed
        // by a sweep at the top of the range and a restart of the time base, either near
        // zero or just short of the wrap.
        clock_ms = NOW_W'($urandom_range(0, 100));
        hold_at  = sent_reqs + 30;
        while (sent_reqs < TOTAL_REQS)
        begin
            calm = (sent_reqs >= TOTAL_REQS - TOTAL_REQS / 8);
            if (!hold_armed && sent_reqs >= hold_at)
            begin
                long_hold_pending = 1'b1;
                hold_armed        = 1'b1;
            end
            if (!calm && $urandom_range(0, 4) == 0)
            begin
                idle_gap();
            end

            pick = $urandom_range(0, 99);
            if (pick < 52)
            begin
                clock_ms += NOW_W'($urandom_range(0, 45));
                send_tick(clock_ms);
            end
            else if (pick < 81)
            begin
                push_request($urandom_range(0, 1) ? REQ_RESUME : REQ_PAUSE, $urandom,
                             IVL_W'($urandom), SLOT_W'($urandom));
            end
            else if (pick < 89)
            begin
                push_request(REQ_ADD, $urandom, IVL_W'($urandom), SLOT_W'($urandom));
            end
            else if (pick < 95)
            begin
                clock_ms += NOW_W'($urandom_range(46, 5000));
                send_tick(clock_ms);
            end
            else
            begin
                send_tick($urandom);
                send_tick(32'hFFFF_FFFF - NOW_W'($urandom_range(0, 3)));
                if ($urandom_range(0, 1) == 1)
                begin
                    clock_ms = NOW_W'($urandom_range(0, 200));
                end
                else
                begin
                    clock_ms = 32'hFFFF_FFFF - NOW_W'($urandom_range(0, 300));
                end
            end
        end
        req.valid <= 1'b0;

        // The checker's count of waiting results is a registered copy of its queue size.
        @(posedge clk);
        while (outstanding != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run covered %0d requests: adds, pauses, resumes and ticks, including",
                 sent_reqs);
        $display("empty, full, unused-slot and wrapping cases; %0d results, %0d firings.",
                 result_count, fired_count);
        if (fail_count == 0 && outstanding == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("%0d mismatches, %0d results never delivered", fail_count, outstanding);
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Result side. Ready comes in stretches: short low bursts, short and long high
    // stretches, and one long hold while the request side keeps offering, so the core
    // fills its output and stops taking requests. Two low bursts never follow each other.
    initial
    begin : result_sink
        int   len;
        logic lvl;

        rsp.ready <= 1'b0;
        lvl = 1'b1;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (long_hold_pending)
            begin
                long_hold_pending = 1'b0;
                lvl = 1'b0;
                len = LONG_HOLD;
            end
            else if (calm)
            begin
                lvl = 1'b1;
                len = 1;
            end
            else if (lvl && $urandom_range(0, 3) == 0)
            begin
                lvl = 1'b0;
                len = $urandom_range(1, 6);
            end
            else if ($urandom_range(0, 5) == 0)
            begin
                lvl = 1'b1;
                len = $urandom_range(20, 60);
            end
            else
            begin
                lvl = 1'b1;
                len = $urandom_range(1, 8);
            end
            rsp.ready <= lvl;
            repeat (len) @(posedge clk);
        end
    end

    // Watchdog: a run in which nothing moves on either channel for too long is hung.
    initial
    begin : watchdog
        int quiet;

        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if (rst_n === 1'b1 && !(req.valid && req.ready) && !(rsp.valid && rsp.ready))
            begin
                quiet++;
            end
            else
            begin
                quiet = 0;
            end
        end
        $display("%0t: no request or result accepted for %0d cycles", $time, STALL_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+sv
sv/ptt_pkg.sv
sv/ptt_if.sv
sv/ptt_ctrl.sv
sv/ptt_dpath.sv
sv/periodic_task_timer_table_core.sv
sv/ptt_chk.sv
bench/ptt_timer_checker.sv
bench/tb_periodic_task_timer_table_core.sv
